// File: rtl/fcr_pkg.sv
package fcr_pkg;

    // Framing characters
    localparam logic [7:0] START_BYTE = 8'h26;
    localparam logic [7:0] STOP_BYTE  = 8'h24;
    localparam logic [7:0] SEP_BYTE   = 8'h3A;
    localparam logic [7:0] ACK_LETTER = 8'h41;
    localparam logic [7:0] DIGIT_BASE = 8'h30;
    localparam logic [5:0] POS_MAX    = 6'd50;

    // Result kinds
    localparam logic [1:0] KIND_CMD = 2'd0;
    localparam logic [1:0] KIND_MSG = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;
    localparam logic [1:0] KIND_ACK = 2'd3;

    // Beat numbers within an acknowledge burst
    localparam logic [1:0] ACK_BEAT_START  = 2'd0;
    localparam logic [1:0] ACK_BEAT_LETTER = 2'd1;
    localparam logic [1:0] ACK_BEAT_CODE   = 2'd2;
    localparam logic [1:0] ACK_BEAT_STOP   = 2'd3;

    // One parsed record handed to the output stage; an acknowledge record
    // carries the ack code in data_byte and expands to four beats.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] block_index;
        logic [5:0] position;
        logic [5:0] command_length;
        logic [5:0] message_length;
        logic [7:0] sender_id;
        logic [7:0] block_count;
        logic [7:0] check_byte;
    } fcr_rec_t;

endpackage

// File: rtl/fcr_parser.sv
module fcr_parser
    import fcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       out_free,
    output logic       rec_load,
    output fcr_rec_t   rec
);

    typedef enum logic [2:0] {
        ST_WAIT = 3'd0,
        ST_ID   = 3'd1,
        ST_LEN  = 3'd2,
        ST_CMD  = 3'd3,
        ST_MSG  = 3'd4,
        ST_ACK  = 3'd5,
        ST_END  = 3'd7
    } state_t;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parse state
    state_t     state_reg,   state_next;
    logic [7:0] sender_reg,  sender_next;
    logic [7:0] declared_reg, declared_next;
    logic [7:0] left_reg,    left_next;
    logic [7:0] counter_reg, counter_next;
    logic [5:0] cmd_pos_reg, cmd_pos_next;
    logic [5:0] msg_pos_reg, msg_pos_next;
    logic [7:0] ack_reg,     ack_next;
    logic [7:0] check_reg,   check_next;

    logic       sep;
    logic       produces;
    logic       consume;
    logic [5:0] cmd_pos_inc;
    logic [5:0] msg_pos_inc;
    logic [7:0] left_dec;

    assign sep         = (in_byte_reg == SEP_BYTE);
    assign cmd_pos_inc = (cmd_pos_reg >= POS_MAX) ? 6'd0 : cmd_pos_reg + 6'd1;
    assign msg_pos_inc = (msg_pos_reg >= POS_MAX) ? 6'd0 : msg_pos_reg + 6'd1;
    assign left_dec    = left_reg - 8'd1;

    // Does the held byte produce a result?
    always_comb begin
        case (state_reg)
            ST_CMD:  produces = !sep;
            ST_MSG:  produces = 1'b1;
            ST_END:  produces = (in_byte_reg == STOP_BYTE);
            default: produces = 1'b0;
        endcase
    end

    // Bytes without a result never wait on the output stage
    assign consume  = in_valid_reg && (out_free || !produces);
    assign s_ready  = !in_valid_reg || consume;
    assign rec_load = consume && produces;

    // Next state and result record
    always_comb begin
        state_next    = state_reg;
        sender_next   = sender_reg;
        declared_next = declared_reg;
        left_next     = left_reg;
        counter_next  = counter_reg;
        cmd_pos_next  = cmd_pos_reg;
        msg_pos_next  = msg_pos_reg;
        ack_next      = ack_reg;
        check_next    = check_reg;

        rec                = '0;
        rec.sender_id      = sender_reg;
        rec.block_count    = declared_reg;
        rec.block_index    = counter_reg;

        case (state_reg)
            ST_WAIT: begin
                if (in_byte_reg == START_BYTE) begin
                    sender_next   = '0;
                    declared_next = '0;
                    left_next     = '0;
                    counter_next  = '0;
                    cmd_pos_next  = '0;
                    msg_pos_next  = '0;
                    state_next    = ST_ID;
                end
            end
            ST_ID: begin
                if (sep) state_next = ST_LEN;
                else     sender_next = in_byte_reg;
            end
            ST_LEN: begin
                if (sep) begin
                    state_next = ST_CMD;
                end else begin
                    declared_next = in_byte_reg - DIGIT_BASE;
                    left_next     = in_byte_reg - DIGIT_BASE;
                end
            end
            ST_CMD: begin
                rec.kind      = KIND_CMD;
                rec.data_byte = in_byte_reg;
                rec.position  = cmd_pos_reg;
                if (sep) state_next   = ST_MSG;
                else     cmd_pos_next = cmd_pos_inc;
            end
            ST_MSG: begin
                if (sep) begin
                    // block end record
                    rec.kind           = KIND_END;
                    rec.command_length = cmd_pos_reg;
                    rec.message_length = msg_pos_reg;
                    cmd_pos_next = '0;
                    msg_pos_next = '0;
                    left_next    = left_dec;
                    counter_next = counter_reg + 8'd1;
                    state_next   = (left_dec == 8'd0) ? ST_ACK : ST_CMD;
                end else begin
                    rec.kind      = KIND_MSG;
                    rec.data_byte = in_byte_reg;
                    rec.position  = msg_pos_reg;
                    msg_pos_next  = msg_pos_inc;
                end
            end
            ST_ACK: begin
                if (sep) state_next = ST_END;
                else     ack_next   = in_byte_reg;
            end
            ST_END: begin
                rec.kind        = KIND_ACK;
                rec.data_byte   = ack_reg;
                rec.block_index = '0;
                rec.check_byte  = check_reg;
                if (in_byte_reg == STOP_BYTE) state_next = ST_WAIT;
                else                          check_next = in_byte_reg;
            end
            default: begin
                state_next = ST_WAIT;
            end
        endcase
    end

    // Input register and parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_WAIT;
            sender_reg   <= '0;
            declared_reg <= '0;
            left_reg     <= '0;
            counter_reg  <= '0;
            cmd_pos_reg  <= '0;
            msg_pos_reg  <= '0;
            ack_reg      <= '0;
            check_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (consume) begin
                state_reg    <= state_next;
                sender_reg   <= sender_next;
                declared_reg <= declared_next;
                left_reg     <= left_next;
                counter_reg  <= counter_next;
                cmd_pos_reg  <= cmd_pos_next;
                msg_pos_reg  <= msg_pos_next;
                ack_reg      <= ack_next;
                check_reg    <= check_next;
            end
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

endmodule

// File: rtl/fcr_out.sv
module fcr_out
    import fcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       rec_load,
    input  fcr_rec_t   rec,
    output logic       out_free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_block_index,
    output logic [5:0] m_position,
    output logic [5:0] m_command_length,
    output logic [5:0] m_message_length,
    output logic [7:0] m_sender_id,
    output logic [7:0] m_block_count,
    output logic [7:0] m_check_byte,
    output logic       m_frame_done,
    output logic       m_last
);

    logic       valid_reg;
    logic [1:0] beat_reg;
    fcr_rec_t   rec_reg;
    logic       is_ack;
    logic       final_beat;

    assign is_ack     = (rec_reg.kind == KIND_ACK);
    assign final_beat = !is_ack || (beat_reg == ACK_BEAT_STOP);
    assign out_free   = !valid_reg || (m_ready && final_beat);

    // Beat sequencing; an acknowledge record expands to four beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= ACK_BEAT_START;
        end else if (rec_load) begin
            valid_reg <= 1'b1;
            beat_reg  <= ACK_BEAT_START;
        end else if (valid_reg && m_ready) begin
            if (final_beat) valid_reg <= 1'b0;
            else            beat_reg  <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_load) begin
            rec_reg <= rec;
        end
    end

    // Acknowledge bytes to transmit
    always_comb begin
        m_data_byte = rec_reg.data_byte;
        if (is_ack) begin
            case (beat_reg)
                ACK_BEAT_START:  m_data_byte = START_BYTE;
                ACK_BEAT_LETTER: m_data_byte = ACK_LETTER;
                ACK_BEAT_CODE:   m_data_byte = rec_reg.data_byte;
                ACK_BEAT_STOP:   m_data_byte = STOP_BYTE;
                default:         m_data_byte = rec_reg.data_byte;
            endcase
        end
    end

    assign m_valid          = valid_reg;
    assign m_kind           = rec_reg.kind;
    assign m_block_index    = rec_reg.block_index;
    assign m_position       = rec_reg.position;
    assign m_command_length = rec_reg.command_length;
    assign m_message_length = rec_reg.message_length;
    assign m_sender_id      = rec_reg.sender_id;
    assign m_block_count    = rec_reg.block_count;
    assign m_check_byte     = rec_reg.check_byte;
    assign m_frame_done     = is_ack && (beat_reg == ACK_BEAT_STOP);
    assign m_last           = final_beat;

endmodule

// File: rtl/framed_command_receiver.sv
// Framed command receiver.
// s_ channel: one received byte per beat (s_rx_byte), valid/ready.
// m_ channel: parsed records, valid/ready. Each command or message byte gives
// one beat tagged with block index and position; the separator closing a
// message gives a block-end beat with both lengths; the stop character gives
// four acknowledge beats ('&', 'A', ack code, '$'), the fourth with
// m_frame_done set. m_last marks the final beat caused by one input byte.
// An accepted byte passes the input register, then the result register, before
// its first result beat. Throughput: one byte per cycle while the result register
// is free; an acknowledge burst holds the result register for its four beats, so
// input bytes with a result back up behind it.
// Bytes that produce no result are consumed even while the result register
// is stalled; a byte with a result waits until the register is free.
// When m_ready is low the current beat is held unchanged.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to waiting for a start character with all counters cleared.
module framed_command_receiver
    import fcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_block_index,
    output logic [5:0] m_position,
    output logic [5:0] m_command_length,
    output logic [5:0] m_message_length,
    output logic [7:0] m_sender_id,
    output logic [7:0] m_block_count,
    output logic [7:0] m_check_byte,
    output logic       m_frame_done,
    output logic       m_last
);

    logic     out_free;
    logic     rec_load;
    fcr_rec_t rec;

    fcr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .out_free  (out_free),
        .rec_load  (rec_load),
        .rec       (rec)
    );

    fcr_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .rec_load         (rec_load),
        .rec              (rec),
        .out_free         (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_data_byte      (m_data_byte),
        .m_block_index    (m_block_index),
        .m_position       (m_position),
        .m_command_length (m_command_length),
        .m_message_length (m_message_length),
        .m_sender_id      (m_sender_id),
        .m_block_count    (m_block_count),
        .m_check_byte     (m_check_byte),
        .m_frame_done     (m_frame_done),
        .m_last           (m_last)
    );

endmodule
